// ===== hdl/hashed_seed_random_chooser_core_macros.svh =====
// Assertion macros for the hashed-seed random chooser.
// Uses the clk and rst_n names of the including module; no other dependencies.
`ifndef HASHED_SEED_RANDOM_CHOOSER_CORE_MACROS_SVH
`define HASHED_SEED_RANDOM_CHOOSER_CORE_MACROS_SVH

// Check that a condition holds in the same cycle as its trigger.
`define HSRC_ASSERT_NOW(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// Check that a condition holds in the cycle after its trigger.
`define HSRC_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// ===== hdl/hsrc_pkg.sv =====
// Shared types, constants and hash functions for the hashed-seed random chooser.
// No dependencies; used by the controller, datapath and top level.
package hsrc_pkg;

    localparam int HASH_STEPS = 6;
    localparam int DIV_BITS   = 32;
    localparam int CNT_W      = 5;

    localparam logic [1:0] MODE_RAW    = 2'd0;
    localparam logic [1:0] MODE_CHOICE = 2'd1;
    localparam logic [1:0] MODE_RANGE  = 2'd2;
    localparam logic [1:0] MODE_CHANCE = 2'd3;

    localparam logic [32:0] CHANCE_BASE = 33'd100;

    typedef struct packed {
        logic       load_seed;
        logic       start_draw;
        logic       hash_en;
        logic [2:0] hash_sel;
        logic       seed_done;
        logic       draw_update;
        logic       div_en;
        logic       load_out;
    } cmd_t;

    function automatic logic [31:0] hash_step(input logic [31:0] k, input logic [2:0] sel);
        logic [31:0] r;
        case (sel)
            3'd0:    r = k + ~(k << 16);
            3'd1:    r = k ^ (k >> 5);
            3'd2:    r = k + (k << 3);
            3'd3:    r = k ^ (k >> 13);
            3'd4:    r = k + ~(k << 9);
            3'd5:    r = k ^ (k >> 17);
            default: r = k;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] wang_hash(input logic [31:0] k);
        logic [31:0] r;
        r = k;
        for (int i = 0; i < HASH_STEPS; i++)
        begin
            r = hash_step(r, 3'(i));
        end
        return r;
    endfunction

    localparam logic [31:0] HASH_OF_ZERO = wang_hash(32'd0);

endpackage

// ===== hdl/hsrc_ctrl.sv =====
// Sequencing state machine for the hashed-seed random chooser.
// Depends on hsrc_pkg for the command struct and step counts.
module hsrc_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic            s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    output hsrc_pkg::cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_SEED_HASH = 3'd1;
    localparam logic [2:0] ST_SEED_SAVE = 3'd2;
    localparam logic [2:0] ST_DRAW_HASH = 3'd3;
    localparam logic [2:0] ST_SETUP     = 3'd4;
    localparam logic [2:0] ST_DIVIDE    = 3'd5;
    localparam logic [2:0] ST_FINISH    = 3'd6;

    localparam logic [hsrc_pkg::CNT_W-1:0] HASH_LAST = hsrc_pkg::CNT_W'(hsrc_pkg::HASH_STEPS - 1);
    localparam logic [hsrc_pkg::CNT_W-1:0] DIV_LAST  = hsrc_pkg::CNT_W'(hsrc_pkg::DIV_BITS - 1);

    logic [2:0]                 state_reg, state_next;
    logic [hsrc_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                       out_valid_reg, out_valid_next;
    logic                       out_free;

    assign cfg_ready = (state_reg == ST_IDLE);
    assign s_tready  = (state_reg == ST_IDLE) && !cfg_valid;
    assign m_tvalid  = out_valid_reg;
    assign out_free  = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd            = '0;
        cmd.hash_sel   = cnt_reg[2:0];
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (cfg_valid)
                begin
                    cmd.load_seed = 1'b1;
                    state_next    = ST_SEED_HASH;
                end
                else if (s_tvalid)
                begin
                    cmd.start_draw = 1'b1;
                    state_next     = ST_DRAW_HASH;
                end
            end
            ST_SEED_HASH:
            begin
                cmd.hash_en = 1'b1;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == HASH_LAST)
                begin
                    state_next = ST_SEED_SAVE;
                end
            end
            ST_SEED_SAVE:
            begin
                cmd.seed_done = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_DRAW_HASH:
            begin
                cmd.hash_en = 1'b1;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == HASH_LAST)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                cmd.draw_update = 1'b1;
                cnt_next        = '0;
                state_next      = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                cmd.div_en = 1'b1;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hdl/hsrc_datapath.sv =====
// Seed words, iterative hash, radix-2 remainder unit and result register.
// Depends on hsrc_pkg for the command struct, mode codes and hash step.
module hsrc_datapath
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  hsrc_pkg::cmd_t        cmd,
    input  logic [31:0]           cfg_data,
    input  logic [1:0]            mode,
    input  logic signed [31:0]    first_operand,
    input  logic signed [31:0]    second_operand,
    output logic signed [32:0]    value,
    output logic                  passed
);

    logic [31:0]        low_reg, high_reg;
    logic [31:0]        hash_reg, hash_next;
    logic [1:0]         mode_reg;
    logic signed [31:0] a_reg, b_reg, lo_reg;
    logic [31:0]        mag_reg, mag_next;
    logic [32:0]        div_reg, div_next;
    logic [31:0]        dvd_reg, rem_reg, rem_next;
    logic signed [32:0] value_reg, value_next;
    logic               passed_reg, passed_next;

    logic               swap;
    logic signed [31:0] lo_sel, hi_sel;
    logic [32:0]        span;
    logic [32:0]        trial;

    assign hash_next = hsrc_pkg::hash_step(hash_reg, cmd.hash_sel);
    assign mag_next  = hash_reg[31] ? (~hash_reg + 32'd1) : hash_reg;

    assign swap   = a_reg > b_reg;
    assign lo_sel = swap ? b_reg : a_reg;
    assign hi_sel = swap ? a_reg : b_reg;
    assign span   = {hi_sel[31], hi_sel} - {lo_sel[31], lo_sel} + 33'd1;

    always_comb
    begin
        case (mode_reg)
            hsrc_pkg::MODE_CHOICE: div_next = (a_reg < 32'sd2) ? 33'd1 : {1'b0, a_reg};
            hsrc_pkg::MODE_RANGE:  div_next = span;
            hsrc_pkg::MODE_CHANCE: div_next = hsrc_pkg::CHANCE_BASE;
            default:               div_next = 33'd1;
        endcase
    end

    assign trial    = {rem_reg, dvd_reg[31]};
    assign rem_next = (trial >= div_reg) ? 32'(trial - div_reg) : trial[31:0];

    always_comb
    begin
        passed_next = 1'b0;
        case (mode_reg)
            hsrc_pkg::MODE_RAW:    value_next = $signed({1'b0, mag_reg});
            hsrc_pkg::MODE_CHOICE: value_next = $signed({1'b0, rem_reg});
            hsrc_pkg::MODE_RANGE:  value_next = $signed({1'b0, rem_reg})
                                              + $signed({lo_reg[31], lo_reg});
            hsrc_pkg::MODE_CHANCE:
            begin
                value_next  = '0;
                passed_next = $signed({1'b0, rem_reg}) < $signed({a_reg[31], a_reg});
            end
            default:               value_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg  <= '0;
            high_reg <= hsrc_pkg::HASH_OF_ZERO;
        end
        else if (cmd.load_seed)
        begin
            low_reg <= cfg_data;
        end
        else if (cmd.seed_done)
        begin
            high_reg <= hash_reg;
        end
        else if (cmd.draw_update)
        begin
            low_reg  <= {high_reg[1:0], hash_reg[31:2]};
            high_reg <= {hash_reg[1:0], high_reg[31:2]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_seed)
        begin
            hash_reg <= cfg_data;
        end
        else if (cmd.start_draw)
        begin
            hash_reg <= low_reg;
            mode_reg <= mode;
            a_reg    <= first_operand;
            b_reg    <= second_operand;
        end
        else if (cmd.hash_en)
        begin
            hash_reg <= hash_next;
        end
        if (cmd.draw_update)
        begin
            mag_reg <= mag_next;
            dvd_reg <= mag_next;
            rem_reg <= '0;
            div_reg <= div_next;
            lo_reg  <= lo_sel;
        end
        else if (cmd.div_en)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[30:0], 1'b0};
        end
        if (cmd.load_out)
        begin
            value_reg  <= value_next;
            passed_reg <= passed_next;
        end
    end

    assign value  = value_reg;
    assign passed = passed_reg;

endmodule

// ===== hdl/hashed_seed_random_chooser_core.sv =====
// Top level of the hashed-seed random chooser: controller plus datapath.
// Depends on hsrc_pkg, hsrc_ctrl, hsrc_datapath and the assertion macro header.
//
//  channel  direction  handshake            payload
//  s_*      in         s_tvalid/s_tready    s_tdata: mode, first_operand, second_operand
//  m_*      out        m_tvalid/m_tready    m_tdata: value, passed
//  cfg_*    in         cfg_valid/cfg_ready  cfg_data: seed_value
//
// An item passes from transfer to result through accept, the hash steps, setup,
// the steps of the radix-2 remainder unit and the load of the output register.
// A seed write runs the same hash sequence; no item is taken meanwhile.
// Reset loads the seed words for seed 0 at once; no clearing pass.
// A result waiting on m_tready stalls the next item only at its final step.
module hashed_seed_random_chooser_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // [1:0] mode, [33:2] first_operand, [65:34] second_operand
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [32:0] value, [33] passed
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

`include "hashed_seed_random_chooser_core_macros.svh"

    hsrc_pkg::cmd_t     cmd;
    logic signed [32:0] value;
    logic               passed;

    hsrc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cmd       (cmd)
    );

    hsrc_datapath u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cfg_data       (cfg_data),
        .mode           (s_tdata[1:0]),
        .first_operand  ($signed(s_tdata[33:2])),
        .second_operand ($signed(s_tdata[65:34])),
        .value          (value),
        .passed         (passed)
    );

    assign m_tdata = {6'd0, passed, value};

    `HSRC_ASSERT_NOW(a_single_start, cfg_valid && cfg_ready, !(s_tvalid && s_tready), "seed write and item transfer in one cycle")
    `HSRC_ASSERT_NEXT(a_busy_after_item, s_tvalid && s_tready, !s_tready && !cfg_ready, "block ready right after item transfer")
    `HSRC_ASSERT_NOW(a_no_overwrite, cmd.load_out, !m_tvalid || m_tready, "result register overwritten before transfer")
    `HSRC_ASSERT_NOW(a_exclusive_units, cmd.hash_en, !cmd.div_en && !cmd.load_out, "hash and divide active together")

endmodule
